@@ hw/rtl/tfwm_pkg.sv @@
// tfwm_pkg: shared widths, request codes, status codes and special characters
// for the topic filter match block; no dependencies

package tfwm_pkg;

    localparam int FUNC_W                = 2;
    localparam int CHAR_W                = 8;
    localparam int STATUS_W              = 2;
    localparam int DEFAULT_MAX_TOPIC_LEN = 256;

    typedef logic [FUNC_W-1:0]   func_t;
    typedef logic [CHAR_W-1:0]   char_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam func_t FUNC_FILTER = 2'd0;
    localparam func_t FUNC_TOPIC  = 2'd1;
    localparam func_t FUNC_RUN    = 2'd2;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_INVALID  = 2'd1;
    localparam status_t ST_TOO_LONG = 2'd2;

    localparam char_t CH_DOLLAR = 8'h24;
    localparam char_t CH_PLUS   = 8'h2B;
    localparam char_t CH_HASH   = 8'h23;
    localparam char_t CH_SLASH  = 8'h2F;

endpackage

@@ hw/rtl/topic_filter_wildcard_match.sv @@
// topic_filter_wildcard_match: byte-wise filter and topic stores with a
// sequencer that checks the filter and walks the match; depends on tfwm_pkg
//
//   channel   signals                     flow
//   request   start, busy, func, char_b.  taken when start is high, busy low
//   result    done, status, matched       done high one cycle, no stall
//
// an append request is taken in idle and busy stays low
// a run request is walked by the sequencer through the single registered read port
// of each store; each character is requested in one state and evaluated in the state after
// results are registered and shown for one cycle; the receiver cannot stall
// reset clears lengths, overflow flag and sequencer; store contents are not cleared

module topic_filter_wildcard_match #(
    parameter int MAX_TOPIC_LEN = tfwm_pkg::DEFAULT_MAX_TOPIC_LEN
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tfwm_pkg::func_t   func,
    input  tfwm_pkg::char_t   char_byte,
    output logic              done,
    output tfwm_pkg::status_t status,
    output logic              matched
);

    import tfwm_pkg::*;

    localparam int LW = $clog2(MAX_TOPIC_LEN + 1);
    localparam int AW = $clog2(MAX_TOPIC_LEN);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_VREQ  = 3'd1;
    localparam logic [2:0] S_VEVAL = 3'd2;
    localparam logic [2:0] S_MREQ  = 3'd3;
    localparam logic [2:0] S_MEVAL = 3'd4;
    localparam logic [2:0] S_XREQ  = 3'd5;
    localparam logic [2:0] S_XEVAL = 3'd6;

    char_t filter_mem [MAX_TOPIC_LEN];
    char_t topic_mem  [MAX_TOPIC_LEN];
    char_t f_rd_reg;
    char_t t_rd_reg;

    logic [2:0]    state_reg, state_next;
    logic [LW-1:0] fl_reg, fl_next;
    logic [LW-1:0] tl_reg, tl_next;
    logic          ovf_reg, ovf_next;
    logic [LW-1:0] si_reg, si_next;
    logic [LW-1:0] ti_reg, ti_next;
    logic          left_ok_reg, left_ok_next;
    logic          plus_pend_reg, plus_pend_next;
    logic          hash_seen_reg, hash_seen_next;
    logic          mis_reg, mis_next;
    logic          done_reg, done_next;
    status_t       status_reg, status_next;
    logic          matched_reg, matched_next;

    logic          accept;
    logic          f_we;
    logic          t_we;
    logic [AW-1:0] f_addr;
    logic [AW-1:0] t_addr;
    logic          bad_char;
    logic          mis_now;
    logic          t_avail;
    logic          near_end;

    assign accept   = start && !busy;
    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign status   = status_reg;
    assign matched  = matched_reg;
    assign f_addr   = si_reg[AW-1:0];
    assign t_addr   = ti_reg[AW-1:0];
    assign t_avail  = (ti_reg < tl_reg);
    assign near_end = (({1'b0, si_reg} + (LW+1)'(2)) == {1'b0, fl_reg});

    // store write and registered read
    always_ff @(posedge clk)
    begin
        if (f_we)
        begin
            filter_mem[fl_reg[AW-1:0]] <= char_byte;
        end
        if (t_we)
        begin
            topic_mem[tl_reg[AW-1:0]] <= char_byte;
        end
        f_rd_reg <= filter_mem[f_addr];
        t_rd_reg <= topic_mem[t_addr];
    end

    always_comb
    begin
        bad_char = 1'b0;
        if (hash_seen_reg)
        begin
            bad_char = 1'b1;
        end
        if (plus_pend_reg && (f_rd_reg != CH_SLASH))
        begin
            bad_char = 1'b1;
        end
        if (((f_rd_reg == CH_PLUS) || (f_rd_reg == CH_HASH)) && !left_ok_reg)
        begin
            bad_char = 1'b1;
        end
        mis_now = (si_reg == '0) ? ((f_rd_reg == CH_DOLLAR) != (t_rd_reg == CH_DOLLAR))
                                 : mis_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        fl_next        = fl_reg;
        tl_next        = tl_reg;
        ovf_next       = ovf_reg;
        si_next        = si_reg;
        ti_next        = ti_reg;
        left_ok_next   = left_ok_reg;
        plus_pend_next = plus_pend_reg;
        hash_seen_next = hash_seen_reg;
        mis_next       = mis_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        matched_next   = matched_reg;
        f_we           = 1'b0;
        t_we           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        FUNC_FILTER:
                        begin
                            if (fl_reg < LW'(MAX_TOPIC_LEN))
                            begin
                                f_we    = 1'b1;
                                fl_next = fl_reg + LW'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        FUNC_TOPIC:
                        begin
                            if (tl_reg < LW'(MAX_TOPIC_LEN))
                            begin
                                t_we    = 1'b1;
                                tl_next = tl_reg + LW'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        FUNC_RUN:
                        begin
                            si_next        = '0;
                            ti_next        = '0;
                            left_ok_next   = 1'b1;
                            plus_pend_next = 1'b0;
                            hash_seen_next = 1'b0;
                            mis_next       = 1'b0;
                            if (ovf_reg || (fl_reg == '0) || (tl_reg == '0))
                            begin
                                done_next    = 1'b1;
                                status_next  = ovf_reg ? ST_TOO_LONG : ST_INVALID;
                                matched_next = 1'b0;
                                fl_next      = '0;
                                tl_next      = '0;
                                ovf_next     = 1'b0;
                            end
                            else
                            begin
                                state_next = S_VREQ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_VREQ:
            begin
                state_next = S_VEVAL;
            end
            S_VEVAL:
            begin
                mis_next       = mis_now;
                left_ok_next   = (f_rd_reg == CH_SLASH);
                plus_pend_next = (f_rd_reg == CH_PLUS);
                hash_seen_next = hash_seen_reg || (f_rd_reg == CH_HASH);
                if (bad_char)
                begin
                    done_next    = 1'b1;
                    status_next  = ST_INVALID;
                    matched_next = 1'b0;
                    state_next   = S_IDLE;
                end
                else if ((si_reg + LW'(1)) == fl_reg)
                begin
                    si_next = '0;
                    if (mis_now)
                    begin
                        done_next    = 1'b1;
                        status_next  = ST_OK;
                        matched_next = 1'b0;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_MREQ;
                    end
                end
                else
                begin
                    si_next    = si_reg + LW'(1);
                    state_next = S_VREQ;
                end
            end
            S_MREQ:
            begin
                if (si_reg == fl_reg)
                begin
                    done_next    = 1'b1;
                    status_next  = ST_OK;
                    matched_next = (ti_reg == tl_reg);
                    state_next   = S_IDLE;
                end
                else
                begin
                    state_next = S_MEVAL;
                end
            end
            S_MEVAL:
            begin
                state_next = S_MREQ;
                if (f_rd_reg == CH_HASH)
                begin
                    done_next    = 1'b1;
                    status_next  = ST_OK;
                    matched_next = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (f_rd_reg == CH_PLUS)
                begin
                    if (t_avail && (t_rd_reg != CH_SLASH))
                    begin
                        ti_next = ti_reg + LW'(1);
                    end
                    else
                    begin
                        si_next = si_reg + LW'(1);
                    end
                end
                else if (t_avail && (t_rd_reg == f_rd_reg))
                begin
                    si_next = si_reg + LW'(1);
                    ti_next = ti_reg + LW'(1);
                end
                else if (!t_avail && near_end && (f_rd_reg == CH_SLASH))
                begin
                    si_next    = si_reg + LW'(1);
                    state_next = S_XREQ;
                end
                else
                begin
                    done_next    = 1'b1;
                    status_next  = ST_OK;
                    matched_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            S_XREQ:
            begin
                state_next = S_XEVAL;
            end
            S_XEVAL:
            begin
                done_next    = 1'b1;
                status_next  = ST_OK;
                matched_next = (f_rd_reg == CH_HASH);
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a finished run clears both stored lengths and the overflow flag
        if (busy && (state_next == S_IDLE))
        begin
            fl_next  = '0;
            tl_next  = '0;
            ovf_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fl_reg    <= '0;
            tl_reg    <= '0;
            ovf_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fl_reg    <= fl_next;
            tl_reg    <= tl_next;
            ovf_reg   <= ovf_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        si_reg        <= si_next;
        ti_reg        <= ti_next;
        left_ok_reg   <= left_ok_next;
        plus_pend_reg <= plus_pend_next;
        hash_seen_reg <= hash_seen_next;
        mis_reg       <= mis_next;
        status_reg    <= status_next;
        matched_reg   <= matched_next;
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while sequencer busy");

    a_match_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> !matched)
        else $error("match bit set on failing status");

    a_overflow_run: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (func == FUNC_RUN) && ovf_reg) |=> (done && (status == ST_TOO_LONG)))
        else $error("overflowed run did not report too long");

    a_cleared_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((fl_reg == '0) && (tl_reg == '0) && !ovf_reg))
        else $error("stores not cleared after run");

    a_walk_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> ((si_reg <= fl_reg) && (ti_reg <= tl_reg)))
        else $error("walk index beyond stored length");

endmodule

@@ test/tb.sv @@
// tb: self-checking testbench for topic_filter_wildcard_match; loads filter and
// topic bytes, runs matches and checks status and matched against its own model
// depends on tfwm_pkg and the topic_filter_wildcard_match rtl
`timescale 1ns / 100ps

module tb;

    import tfwm_pkg::*;

    localparam int    MAX_LEN      = DEFAULT_MAX_TOPIC_LEN;
    localparam func_t FUNC_SPARE   = 2'd3;
    localparam int    RANDOM_ITEMS = 240;
    localparam int    CYCLE_LIMIT  = 300000;
    localparam int    SETTLE       = 50;

    typedef struct packed {
        func_t func;
        char_t ch;
        bit    drain;
    } req_t;

    typedef struct packed {
        status_t status;
        logic    matched;
    } verdict_t;

    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    start     = 1'b0;
    func_t   func      = FUNC_FILTER;
    char_t   char_byte = 8'h00;
    logic    busy;
    logic    done;
    status_t status;
    logic    matched;

    req_t     request_q[$];
    verdict_t verdict_q[$];
    char_t    filt_bytes[$];
    char_t    topic_bytes[$];

    // predicted block state
    char_t filt_mem[MAX_LEN];
    char_t topic_mem[MAX_LEN];
    int    filt_len = 0;
    int    topic_len = 0;
    bit    overflow = 1'b0;

    int total_req = 0;
    int item_cnt = 0;
    int accepted_cnt = 0;
    int mismatches = 0;
    int gap_left = 0;
    int calm_left = 0;
    int cycle_cnt = 0;

    topic_filter_wildcard_match #(
        .MAX_TOPIC_LEN(MAX_LEN)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .func(func),
        .char_byte(char_byte),
        .done(done),
        .status(status),
        .matched(matched)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit filter_well_formed();
        bit left_ok;
        bit right_ok;
        for (int i = 0; i < filt_len; i++)
        begin
            left_ok = (i == 0) || (filt_mem[i-1] == CH_SLASH);
            if (filt_mem[i] == CH_PLUS)
            begin
                right_ok = (i + 1 == filt_len) || (filt_mem[i+1] == CH_SLASH);
                if (!left_ok || !right_ok)
                    return 1'b0;
            end
            else if (filt_mem[i] == CH_HASH)
            begin
                if (!left_ok || i + 1 != filt_len)
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic bit topic_fits_filter();
        int    si = 0;
        int    ti = 0;
        char_t c;
        while (si < filt_len)
        begin
            c = filt_mem[si];
            if (c == CH_HASH)
                return 1'b1;
            if (c == CH_PLUS)
            begin
                while (ti < topic_len && topic_mem[ti] != CH_SLASH)
                    ti++;
                si++;
            end
            else if (ti < topic_len && topic_mem[ti] == c)
            begin
                si++;
                ti++;
            end
            else if (ti == topic_len && si + 2 == filt_len && c == CH_SLASH &&
                     filt_mem[si+1] == CH_HASH)
                return 1'b1;
            else
                return 1'b0;
        end
        return ti == topic_len;
    endfunction

    task automatic predict_request(input func_t f, input char_t c);
        verdict_t v;
        v = '{status: ST_OK, matched: 1'b0};
        case (f)
            FUNC_FILTER:
                if (filt_len < MAX_LEN)
                begin
                    filt_mem[filt_len] = c;
                    filt_len++;
                end
                else
                    overflow = 1'b1;
            FUNC_TOPIC:
                if (topic_len < MAX_LEN)
                begin
                    topic_mem[topic_len] = c;
                    topic_len++;
                end
                else
                    overflow = 1'b1;
            FUNC_RUN:
            begin
                if (overflow)
                    v.status = ST_TOO_LONG;
                else if (filt_len == 0 || topic_len == 0)
                    v.status = ST_INVALID;
                else if (!filter_well_formed())
                    v.status = ST_INVALID;
                else if ((filt_mem[0] == CH_DOLLAR) != (topic_mem[0] == CH_DOLLAR))
                    v.status = ST_OK;
                else
                    v.matched = topic_fits_filter();
                filt_len = 0;
                topic_len = 0;
                overflow = 1'b0;
                verdict_q.push_back(v);
            end
            default: ;
        endcase
    endtask

    task automatic push_req(input func_t f, input char_t c);
        request_q.push_back('{func: f, ch: c, drain: 1'b0});
        total_req++;
        if (f != FUNC_SPARE)
            item_cnt++;
    endtask

    task automatic push_drain();
        request_q.push_back('{func: FUNC_FILTER, ch: 8'h00, drain: 1'b1});
    endtask

    // interleaves the staged filter and topic bytes, with an occasional spare request, then a run request
    task automatic emit_run();
        bit pick_topic;
        while (filt_bytes.size() != 0 || topic_bytes.size() != 0)
        begin
            if (filt_bytes.size() == 0)
                pick_topic = 1'b1;
            else if (topic_bytes.size() == 0)
                pick_topic = 1'b0;
            else
                pick_topic = $urandom_range(0, 1);
            if (pick_topic)
                push_req(FUNC_TOPIC, topic_bytes.pop_front());
            else
                push_req(FUNC_FILTER, filt_bytes.pop_front());
            if ($urandom_range(0, 29) == 0)
                push_req(FUNC_SPARE, char_t'($urandom_range(0, 255)));
        end
        push_req(FUNC_RUN, char_t'($urandom_range(0, 255)));
    endtask

    task automatic emit_text(input string f, input string t);
        for (int i = 0; i < f.len(); i++)
            filt_bytes.push_back(char_t'(f[i]));
        for (int i = 0; i < t.len(); i++)
            topic_bytes.push_back(char_t'(t[i]));
        emit_run();
    endtask

    task automatic stage_word(input bit to_topic);
        int n;
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++)
            if (to_topic)
                topic_bytes.push_back(char_t'(8'h61 + $urandom_range(0, 2)));
            else
                filt_bytes.push_back(char_t'(8'h61 + $urandom_range(0, 2)));
    endtask

    // filter built from literal, single-level and multi-level parts with a
    // topic shaped to match it most of the time
    task automatic stage_well_formed();
        int    levels;
        int    kind;
        int    extra;
        int    mark;
        levels = $urandom_range(1, 4);
        for (int l = 0; l < levels; l++)
        begin
            if (l > 0)
            begin
                filt_bytes.push_back(CH_SLASH);
                topic_bytes.push_back(CH_SLASH);
            end
            kind = $urandom_range(0, 9);
            if (kind == 8 && l == levels - 1)
            begin
                filt_bytes.push_back(CH_HASH);
                extra = $urandom_range(0, 2);
                if (extra == 0 && l > 0)
                    void'(topic_bytes.pop_back());
                for (int k = 0; k < extra; k++)
                begin
                    if (k > 0)
                        topic_bytes.push_back(CH_SLASH);
                    stage_word(1'b1);
                end
            end
            else if (kind >= 6 && kind <= 7)
            begin
                filt_bytes.push_back(CH_PLUS);
                stage_word(1'b1);
            end
            else
            begin
                mark = filt_bytes.size();
                stage_word(1'b0);
                if ($urandom_range(0, 5) == 0)
                    stage_word(1'b1);
                else
                    for (int k = mark; k < filt_bytes.size(); k++)
                        topic_bytes.push_back(filt_bytes[k]);
            end
        end
        if ($urandom_range(0, 7) == 0)
        begin
            topic_bytes.push_back(CH_SLASH);
            stage_word(1'b1);
        end
        if ($urandom_range(0, 7) == 0)
        begin
            kind = $urandom_range(0, 2);
            if (kind != 1)
                filt_bytes.push_front(CH_DOLLAR);
            if (kind != 0)
                topic_bytes.push_front(CH_DOLLAR);
        end
    endtask

    function automatic char_t noise_char();
        case ($urandom_range(0, 5))
            0: return CH_PLUS;
            1: return CH_HASH;
            2: return CH_SLASH;
            3: return CH_DOLLAR;
            default: return char_t'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic stage_long(input int nf, input int nt, input bit same);
        char_t c;
        for (int i = 0; i < nf; i++)
        begin
            c = ($urandom_range(0, 4) == 0) ? CH_SLASH : char_t'(8'h61 + $urandom_range(0, 2));
            filt_bytes.push_back(c);
            if (same)
                topic_bytes.push_back(c);
        end
        for (int i = 0; i < nt; i++)
            topic_bytes.push_back(char_t'(8'h61 + $urandom_range(0, 2)));
        emit_run();
    endtask

    function automatic int next_gap();
        int p;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        p = $urandom_range(0, 99);
        if (p < 3)
        begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (p < 55)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin : driver
        req_t r;
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            if (start && !busy)
            begin
                predict_request(func, char_byte);
                accepted_cnt++;
            end
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (request_q.size() != 0 && request_q[0].drain)
                begin
                    if (verdict_q.size() == 0)
                        void'(request_q.pop_front());
                    start <= 1'b0;
                end
                else if (request_q.size() != 0)
                begin
                    r = request_q.pop_front();
                    func <= r.func;
                    char_byte <= r.ch;
                    start <= 1'b1;
                    gap_left = next_gap();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        verdict_t want;
        if (rst_n && done === 1'b1)
        begin
            if (verdict_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d matched %0b", status, matched);
            end
            else
            begin
                want = verdict_q.pop_front();
                if (status !== want.status || matched !== want.matched)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %0d/%0b, got %0d/%0b",
                                 want.status, want.matched, status, matched);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("topic_filter_wildcard_match: mismatch");
            $finish;
        end
    end

    initial
    begin
        int base;
        int kind;

        // directed requests
        emit_text("", "");
        emit_text("a", "a");
        push_req(FUNC_SPARE, 8'hFF);
        emit_text("#", "$x");
        emit_text("a/#", "a");
        emit_text("a+", "a");
        filt_bytes.push_back(8'h00);
        topic_bytes.push_back(8'h00);
        emit_run();
        filt_bytes.push_back(8'hFF);
        emit_run();

        // one store filled and overrun while the other stays empty
        push_drain();
        if ($urandom_range(0, 1) != 0)
            stage_long(MAX_LEN + 1, 0, 1'b0);
        else
            stage_long(0, MAX_LEN + 1, 1'b0);

        base = item_cnt;
        while (item_cnt - base < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 14)
                stage_well_formed();
            else if (kind < 17)
            begin
                stage_well_formed();
                filt_bytes.insert($urandom_range(0, filt_bytes.size()),
                                  ($urandom_range(0, 1) != 0) ? CH_PLUS : CH_HASH);
            end
            else
            begin
                repeat ($urandom_range(0, 6))
                    filt_bytes.push_back(noise_char());
                repeat ($urandom_range(0, 6))
                    topic_bytes.push_back(noise_char());
            end
            emit_run();
            if ($urandom_range(0, 24) == 0)
                push_drain();
        end

        repeat (5) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (accepted_cnt < total_req || verdict_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (mismatches == 0 && verdict_q.size() == 0)
            $display("topic_filter_wildcard_match: match");
        else
            $display("topic_filter_wildcard_match: mismatch");
        $finish;
    end

endmodule
